FILE: rtl/ssfp_pkg.sv
// Shared types and constants for the servo status frame parser.
// No dependencies; every other file in rtl imports this package.
package ssfp_pkg;

	localparam int MAX_PARAMS_DEF = 32;
	localparam int OUT_LIMIT = 32;
	localparam int CNT_W = 6;
	localparam int IDX_W = 6;
	localparam int OUTQ_DEPTH = 4;

	localparam logic [7:0] HDR_BYTE = 8'hFF;
	localparam logic [7:0] MIN_LEN = 8'd2;

	localparam logic REG_EXPECTED_ID = 1'b0;
	localparam logic REG_EXPECTED_LEN = 1'b1;

	typedef enum logic [2:0] {
		PH_HUNT1 = 3'd0,
		PH_HUNT2 = 3'd1,
		PH_ID = 3'd2,
		PH_LEN = 3'd3,
		PH_ERR = 3'd4,
		PH_PARAM = 3'd5,
		PH_CHK = 3'd6
	} phase_t;

	typedef struct packed {
		logic valid;
		logic bank;
		logic [IDX_W-1:0] idx;
		logic [7:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic bank;
		logic [CNT_W-1:0] count;
	} cmd_t;

	typedef struct packed {
		logic [7:0] data;
		logic [4:0] idx;
		logic last;
	} out_t;

endpackage

FILE: rtl/servo_status_frame_parser.sv
// Top level of the servo status frame parser: configuration registers and block wiring.
// Depends on ssfp_pkg, ssfp_front, ssfp_cmdq and ssfp_back.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------
//  bytes in  | push / full        | rx_byte[7:0]
//  results   | empty / pop        | data_byte[7:0], byte_index[4:0], last
//  config    | cfg_we             | cfg_addr[0], cfg_wdata[7:0]
//
// The parser state machine takes one received byte per cycle while full is low.
// A good frame's results pass the request queue, store read register and result queue;
// they then follow one per cycle while pop is held, set by the store's single read port.
// full rises while two accepted frames still hold both banks of the parameter store.
// Reset clears control state only; the store needs no clearing pass.
module servo_status_frame_parser import ssfp_pkg::*; #(
	parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] rx_byte,
	output logic empty,
	input logic pop,
	output logic [7:0] data_byte,
	output logic [4:0] byte_index,
	output logic last,
	input logic cfg_we,
	input logic cfg_addr,
	input logic [7:0] cfg_wdata
);

	logic [7:0] expected_id_q;
	logic [5:0] expected_len_q;
	logic in_valid;
	mem_wr_t mem_wr;
	cmd_t push_cmd, head;
	logic cmd_push, head_valid, head_pop, cmdq_full;
	logic [1:0] cmdq_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_id_q <= 8'd1;
			expected_len_q <= 6'd2;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_EXPECTED_ID: expected_id_q <= cfg_wdata;
				REG_EXPECTED_LEN: expected_len_q <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	assign full = cmdq_full;
	assign in_valid = push && !cmdq_full;

	ssfp_front #(.MAX_PARAMS(MAX_PARAMS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.rx_byte(rx_byte),
		.expected_id(expected_id_q),
		.expected_len(expected_len_q),
		.mem_wr(mem_wr),
		.cmd(push_cmd),
		.cmd_push(cmd_push)
	);

	ssfp_cmdq u_cmdq (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.push_cmd(push_cmd),
		.pop(head_pop),
		.head(head),
		.valid(head_valid),
		.full(cmdq_full),
		.count(cmdq_count)
	);

	ssfp_back #(.MAX_PARAMS(MAX_PARAMS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.mem_wr(mem_wr),
		.head(head),
		.head_valid(head_valid),
		.head_pop(head_pop),
		.pop(pop),
		.empty(empty),
		.data_byte(data_byte),
		.byte_index(byte_index),
		.last(last)
	);

`ifndef SYNTHESIS
	// The parser must never overwrite the bank that the emitter is still reading.
	a_bank_guard: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_wr.valid && head_valid) |-> (mem_wr.bank != head.bank))
		else $error("parameter store write hit the bank being emitted");

	// A frame is only accepted while a free bank is available.
	a_cmd_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> (cmdq_count != 2'd2))
		else $error("emit request pushed into a full request queue");

	// The emitter retires a request only when one is pending.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> head_valid)
		else $error("emit request retired from an empty queue");

	// Queue depth follows its push and pop history.
	a_cmd_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_push && !head_pop) |=> (cmdq_count == $past(cmdq_count) + 2'd1))
		else $error("request queue count out of step");
`endif

endmodule

FILE: rtl/ssfp_front.sv
// Byte-level frame parser: header hunt, field capture, checksum and accept decision.
// Depends on ssfp_pkg; writes parameters into the back end's store and queues emit requests.
module ssfp_front import ssfp_pkg::*; #(
	parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [7:0] rx_byte,
	input logic [7:0] expected_id,
	input logic [5:0] expected_len,
	output mem_wr_t mem_wr,
	output cmd_t cmd,
	output logic cmd_push
);

	localparam int LIMIT = (MAX_PARAMS < OUT_LIMIT) ? MAX_PARAMS : OUT_LIMIT;
	localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);
	localparam logic [7:0] MAXP_C = 8'(MAX_PARAMS);

	phase_t phase_q, phase_d;
	logic [7:0] id_q, id_d;
	logic [7:0] len_q, len_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] seen_q, seen_d;
	logic err_clr_q, err_clr_d;
	logic bank_q, bank_d;
	logic [7:0] seen_inc;
	logic [8:0] seen_plus2;
	logic good;
	logic [CNT_W-1:0] count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			id_q <= '0;
			len_q <= '0;
			sum_q <= '0;
			seen_q <= '0;
			err_clr_q <= 1'b0;
			bank_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			id_q <= id_d;
			len_q <= len_d;
			sum_q <= sum_d;
			seen_q <= seen_d;
			err_clr_q <= err_clr_d;
			bank_q <= bank_d;
		end
	end

	assign seen_inc = seen_q + 8'd1;
	assign seen_plus2 = {1'b0, seen_inc} + 9'd2;
	assign count = ({1'b0, expected_len} > {1'b0, LIMIT_C}) ? LIMIT_C : CNT_W'(expected_len);
	assign good = (id_q == expected_id) && err_clr_q && (rx_byte == ~sum_q) &&
		((len_q - MIN_LEN) >= {2'b00, expected_len});

	always_comb begin
		phase_d = phase_q;
		id_d = id_q;
		len_d = len_q;
		sum_d = sum_q;
		seen_d = seen_q;
		err_clr_d = err_clr_q;
		bank_d = bank_q;
		mem_wr = '0;
		mem_wr.bank = bank_q;
		mem_wr.idx = seen_q[IDX_W-1:0];
		mem_wr.data = rx_byte;
		cmd.bank = bank_q;
		cmd.count = count;
		cmd_push = 1'b0;
		if (in_valid) begin
			case (phase_q)
				PH_HUNT1: begin
					if (rx_byte == HDR_BYTE)
						phase_d = PH_HUNT2;
				end
				PH_HUNT2: begin
					phase_d = (rx_byte == HDR_BYTE) ? PH_ID : PH_HUNT1;
				end
				PH_ID: begin
					id_d = rx_byte;
					sum_d = rx_byte;
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					len_d = rx_byte;
					sum_d = sum_q + rx_byte;
					phase_d = (rx_byte < MIN_LEN) ? PH_HUNT1 : PH_ERR;
				end
				PH_ERR: begin
					err_clr_d = (rx_byte == 8'd0);
					sum_d = sum_q + rx_byte;
					seen_d = '0;
					phase_d = (len_q == MIN_LEN) ? PH_CHK : PH_PARAM;
				end
				PH_PARAM: begin
					// Parameters past the store depth still count toward the sum.
					mem_wr.valid = (seen_q < MAXP_C);
					sum_d = sum_q + rx_byte;
					seen_d = seen_inc;
					if (seen_plus2 >= {1'b0, len_q})
						phase_d = PH_CHK;
				end
				PH_CHK: begin
					phase_d = PH_HUNT1;
					if (good && (count != '0)) begin
						cmd_push = 1'b1;
						bank_d = ~bank_q;
					end
				end
				default: begin
					phase_d = PH_HUNT1;
				end
			endcase
		end
	end

endmodule

FILE: rtl/ssfp_cmdq.sv
// Two-entry queue of emit requests between the parser and the emitter.
// Depends on ssfp_pkg for the request type.
module ssfp_cmdq import ssfp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cmd_t push_cmd,
	input logic pop,
	output cmd_t head,
	output logic valid,
	output logic full,
	output logic [1:0] count
);

	cmd_t ent_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= push_cmd;
	end

	assign head = ent_q[rp_q];
	assign valid = (cnt_q != 2'd0);
	assign full = (cnt_q == 2'd2);
	assign count = cnt_q;

endmodule

FILE: rtl/ssfp_back.sv
// Emitter: two-bank parameter store, read sequencer and a small result queue.
// Depends on ssfp_pkg; takes store writes from ssfp_front and requests from ssfp_cmdq.
module ssfp_back import ssfp_pkg::*; #(
	parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
	input logic clk,
	input logic arst_n,
	input mem_wr_t mem_wr,
	input cmd_t head,
	input logic head_valid,
	output logic head_pop,
	input logic pop,
	output logic empty,
	output logic [7:0] data_byte,
	output logic [4:0] byte_index,
	output logic last
);

	localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
	localparam int DEPTH = 2 * (2 ** IW);
	localparam int PW = $clog2(OUTQ_DEPTH);
	localparam int QCW = $clog2(OUTQ_DEPTH + 2);

	logic [7:0] mem [DEPTH];
	logic [CNT_W-1:0] k_q;
	logic busy_s1;
	logic [7:0] rdata_s1;
	logic [4:0] idx_s1;
	logic last_s1;
	out_t ent_q [OUTQ_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [QCW-1:0] cnt_q;
	logic issue, last_issue, deq;
	out_t head_ent;

	// Space is reserved for the read in flight so the queue never overflows.
	assign issue = head_valid &&
		((cnt_q + QCW'(busy_s1)) < QCW'(OUTQ_DEPTH));
	assign last_issue = ((k_q + CNT_W'(1)) == head.count);
	assign head_pop = issue && last_issue;
	assign deq = pop && (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (mem_wr.valid)
			mem[{mem_wr.bank, mem_wr.idx[IW-1:0]}] <= mem_wr.data;
		if (issue) begin
			rdata_s1 <= mem[{head.bank, k_q[IW-1:0]}];
			idx_s1 <= k_q[4:0];
			last_s1 <= last_issue;
		end
		if (busy_s1)
			ent_q[wp_q] <= '{data: rdata_s1, idx: idx_s1, last: last_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			busy_s1 <= 1'b0;
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			busy_s1 <= issue;
			if (issue)
				k_q <= last_issue ? '0 : k_q + CNT_W'(1);
			if (busy_s1)
				wp_q <= wp_q + PW'(1);
			if (deq)
				rp_q <= rp_q + PW'(1);
			cnt_q <= cnt_q + QCW'(busy_s1) - QCW'(deq);
		end
	end

	assign head_ent = ent_q[rp_q];
	assign empty = (cnt_q == '0);
	assign data_byte = head_ent.data;
	assign byte_index = head_ent.idx;
	assign last = head_ent.last;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for servo_status_frame_parser: drives received bus bytes,
// predicts the parameter bytes of accepted status frames and checks each one.
// Depends on ssfp_pkg and the RTL under rtl/.
module tb_top;
	import ssfp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic pop = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_addr = REG_EXPECTED_ID;
	logic [7:0] cfg_wdata = 8'h00;
	logic full;
	logic empty;
	logic [7:0] data_byte;
	logic [4:0] byte_index;
	logic last;

	// Predicted frame parser state and register copies.
	phase_t p_phase = PH_HUNT1;
	logic [7:0] p_id = 8'h00;
	logic [7:0] p_len = 8'h00;
	logic [7:0] p_sum = 8'h00;
	logic [7:0] p_seen = 8'h00;
	logic p_err_clear = 1'b0;
	logic [7:0] p_store [MAX_PARAMS_DEF];
	logic [7:0] cfg_id = 8'd1;
	logic [5:0] cfg_len = 6'd2;

	out_t predicted_params [$];
	int mismatches = 0;
	int results_seen = 0;
	int bytes_sent = 0;
	int cycle_count = 0;
	int send_idle_pct = 10;
	int recv_stall_pct = 61;
	int hold_cycles = 0;

	servo_status_frame_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.data_byte(data_byte),
		.byte_index(byte_index),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Advances the predicted parser by one received byte and queues any emitted bytes.
	function automatic void track_frame_byte(input logic [7:0] b);
		int nparams;
		int count;
		out_t item;
		case (p_phase)
			PH_HUNT1: begin
				if (b == HDR_BYTE)
					p_phase = PH_HUNT2;
			end
			PH_HUNT2: p_phase = (b == HDR_BYTE) ? PH_ID : PH_HUNT1;
			PH_ID: begin
				p_id = b;
				p_sum = b;
				p_phase = PH_LEN;
			end
			PH_LEN: begin
				p_len = b;
				p_sum = p_sum + b;
				p_phase = (b < MIN_LEN) ? PH_HUNT1 : PH_ERR;
			end
			PH_ERR: begin
				p_err_clear = (b == 8'h00);
				p_sum = p_sum + b;
				p_seen = 8'h00;
				p_phase = (p_len == MIN_LEN) ? PH_CHK : PH_PARAM;
			end
			PH_PARAM: begin
				// Bytes past the store depth still count toward the sum and length.
				if (int'(p_seen) < MAX_PARAMS_DEF)
					p_store[p_seen[4:0]] = b;
				p_sum = p_sum + b;
				p_seen = p_seen + 8'd1;
				if (int'(p_seen) + 2 >= int'(p_len))
					p_phase = PH_CHK;
			end
			PH_CHK: begin
				p_phase = PH_HUNT1;
				nparams = int'(p_len) - 2;
				if (p_id == cfg_id && p_err_clear && b == ~p_sum &&
						nparams >= int'(cfg_len)) begin
					count = int'(cfg_len);
					if (count > MAX_PARAMS_DEF)
						count = MAX_PARAMS_DEF;
					if (count > OUT_LIMIT)
						count = OUT_LIMIT;
					for (int k = 0; k < count; k++) begin
						item.data = p_store[5'(k)];
						item.idx = 5'(k);
						item.last = (k == count - 1);
						predicted_params.insert(predicted_params.size(), item);
					end
				end
			end
			default: p_phase = PH_HUNT1;
		endcase
	endfunction

	// Result side: checks every accepted result and drives pop.
	always @(posedge clk) begin
		out_t want;
		if (pop && !empty) begin
			results_seen++;
			if (predicted_params.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: data %02h index %0d last %0b",
						data_byte, byte_index, last);
			end else begin
				want = predicted_params.pop_front();
				if (data_byte !== want.data || byte_index !== want.idx ||
						last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result %0d: expected data %02h index %0d last %0b,",
							" got data %02h index %0d last %0b"},
							results_seen, want.data, want.idx, want.last,
							data_byte, byte_index, last);
				end
			end
		end
		if (!arst_n)
			pop <= 1'b0;
		else if (hold_cycles > 0) begin
			hold_cycles--;
			pop <= 1'b0;
		end else
			pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Offers one byte and returns at the edge that accepts it; push stays high.
	task automatic send_byte(input logic [7:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= value;
		do @(posedge clk); while (full);
		bytes_sent++;
		track_frame_byte(value);
	endtask

	task automatic send_status_frame(input logic [7:0] id, input logic [7:0] len_byte,
			input logic [7:0] err, input bit bad_sum, input bit extreme_fill);
		logic [7:0] sum;
		logic [7:0] val;
		send_byte(HDR_BYTE);
		send_byte(HDR_BYTE);
		send_byte(id);
		send_byte(len_byte);
		if (len_byte < MIN_LEN)
			return;
		send_byte(err);
		sum = id + len_byte + err;
		for (int k = 0; k < int'(len_byte) - 2; k++) begin
			val = extreme_fill ? ((k % 2 == 1) ? 8'hFF : 8'h00) : 8'($urandom);
			sum = sum + val;
			send_byte(val);
		end
		val = ~sum;
		if (bad_sum)
			val = val ^ 8'(1 << $urandom_range(7));
		send_byte(val);
	endtask

	// Brings the parser back to hunting, then waits until every expected result is out.
	task automatic settle();
		while (p_phase != PH_HUNT1)
			send_byte(8'h00);
		push <= 1'b0;
		while (predicted_params.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] id, input logic [5:0] len);
		cfg_we <= 1'b1;
		cfg_addr <= REG_EXPECTED_ID;
		cfg_wdata <= id;
		@(posedge clk);
		cfg_addr <= REG_EXPECTED_LEN;
		cfg_wdata <= {2'b00, len};
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_id = id;
		cfg_len = len;
	endtask

	task automatic send_random_request();
		int pick;
		int nparams;
		logic [7:0] id;
		logic [7:0] err;
		logic [7:0] len_byte;
		pick = $urandom_range(99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 3))
				send_byte(($urandom_range(3) == 0) ? HDR_BYTE : 8'($urandom));
		end else if (pick < 12) begin
			send_byte(HDR_BYTE);
			send_byte(8'($urandom_range(254)));
		end else begin
			id = ($urandom_range(99) < 85) ? cfg_id : 8'($urandom);
			err = ($urandom_range(99) < 85) ? 8'h00 : 8'($urandom);
			pick = $urandom_range(99);
			if (pick < 14 && cfg_len > 0)
				nparams = $urandom_range(int'(cfg_len) - 1);
			else if (pick < 18)
				nparams = int'(cfg_len) + $urandom_range(40);
			else
				nparams = int'(cfg_len) + $urandom_range(2);
			len_byte = 8'(nparams + 2);
			if ($urandom_range(99) < 4)
				len_byte = 8'($urandom_range(1));
			send_status_frame(id, len_byte, err, $urandom_range(99) < 10, 1'b0);
		end
	endtask

	task automatic test_frame_errors();
		// Broken header, then a third header byte taken as id with a short length.
		send_byte(HDR_BYTE);
		send_byte(8'h00);
		send_byte(HDR_BYTE);
		send_byte(HDR_BYTE);
		send_byte(HDR_BYTE);
		send_byte(8'h01);
		send_status_frame(cfg_id, 8'h00, 8'h00, 1'b0, 1'b0);
		send_status_frame(cfg_id, 8'h04, 8'h00, 1'b0, 1'b1);
		send_status_frame(cfg_id, 8'h04, 8'h80, 1'b0, 1'b0);
		send_status_frame(cfg_id, 8'h03, 8'h00, 1'b0, 1'b0);
		send_status_frame(cfg_id, 8'h04, 8'h00, 1'b1, 1'b0);
		send_status_frame(cfg_id + 8'd1, 8'h04, 8'h00, 1'b0, 1'b0);
		settle();
	endtask

	task automatic test_config_extremes();
		// With nothing requested a good frame is accepted but emits no bytes.
		set_config(8'h00, 6'd0);
		send_status_frame(8'h00, 8'h02, 8'h00, 1'b0, 1'b0);
		send_status_frame(8'h00, 8'h05, 8'h00, 1'b0, 1'b0);
		settle();
		// Oversized request: output saturates at the store depth.
		set_config(8'hFF, 6'd63);
		send_status_frame(8'hFF, 8'd42, 8'h00, 1'b0, 1'b0);
		send_status_frame(8'hFF, 8'd65, 8'h00, 1'b0, 1'b0);
		settle();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input logic [7:0] id, input logic [5:0] len, input int count);
		int start;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		set_config(id, len);
		start = bytes_sent;
		while (bytes_sent - start < count)
			send_random_request();
		settle();
	endtask

	// The receiver stops popping for a long stretch while good frames keep coming,
	// so the parameter store fills and the byte input stalls.
	task automatic test_output_hold();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_config(8'($urandom), 6'd4);
		hold_cycles = 400;
		repeat (6)
			send_status_frame(cfg_id, 8'd6, 8'h00, 1'b0, 1'b0);
		settle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_config(8'd1, 6'd2);
		test_frame_errors();
		test_config_extremes();
		test_random_traffic(10, 61, 8'($urandom), 6'($urandom_range(1, 6)), 80);
		test_random_traffic(61, 10, 8'($urandom), 6'd32, 80);
		test_random_traffic(0, 0, 8'($urandom), 6'd1, 80);
		test_output_hold();
		while (predicted_params.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += predicted_params.size();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
